/* rtl/priority_work_stealing_deques_assert.svh */
// assertion macros for the task queue block
`ifndef PRIORITY_WORK_STEALING_DEQUES_ASSERT_SVH
`define PRIORITY_WORK_STEALING_DEQUES_ASSERT_SVH

`ifndef SYNTHESIS

`define PWSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PWSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define PWSD_ASSERT(lbl, prop, msg)

`define PWSD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/pwsd_pkg.sv */
`timescale 1ns / 1ps

package pwsd_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_STEAL = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic signed [2:0] LEVEL_NONE = -3'sd1;

  typedef struct packed {
    status_e     status;
    logic        take;
    logic [2:0]  task_level;
  } resp_t;

endpackage

/* rtl/pwsd_store.sv */
`timescale 1ns / 1ps

module pwsd_store #(
  parameter int unsigned ENTRIES = 192,
  parameter int unsigned AW      = 8,
  parameter int unsigned DW      = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pwsd_ctrl.sv */
`timescale 1ns / 1ps

module pwsd_ctrl #(
  parameter int unsigned LEVELS = 3,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned AW     = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [1:0]     action_i,
  input  logic [1:0]     level_i,
  output logic           mem_we_o,
  output logic           mem_re_o,
  output logic [AW-1:0]  mem_addr_o,
  output pwsd_pkg::resp_t resp_o
);

  import pwsd_pkg::*;

  localparam int unsigned IW   = $clog2(DEPTH) + 1;
  localparam int unsigned LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned RING = 2 * DEPTH;

  logic [IW-1:0] top_q [LEVELS];
  logic [IW-1:0] top_d [LEVELS];
  logic [IW-1:0] bot_q [LEVELS];
  logic [IW-1:0] bot_d [LEVELS];

  logic [LW-1:0] lv;
  logic          lv_ok;
  logic [IW-1:0] t;
  logic [IW-1:0] b;
  logic [IW-1:0] b_prev;
  logic [IW-1:0] fill;
  logic          empty;
  logic          full;
  action_e       act;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    r = (32'(i) + 1 >= RING) ? '0 : IW'(32'(i) + 1);
    return r;
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    r = (i == '0) ? IW'(RING - 1) : IW'(32'(i) - 1);
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [LW-1:0] l, input logic [IW-1:0] i);
    logic [31:0] s;
    s = (32'(i) >= DEPTH) ? 32'(i) - DEPTH : 32'(i);
    return AW'(32'(l) * DEPTH + s);
  endfunction

  always_comb begin
    act    = action_e'(action_i);
    lv     = LW'(level_i);
    lv_ok  = 32'(level_i) < LEVELS;
    t      = top_q[lv];
    b      = bot_q[lv];
    b_prev = ring_prev(b);
    fill   = (b >= t) ? IW'(b - t) : IW'(32'(b) + RING - 32'(t));
    empty  = fill == '0;
    full   = 32'(fill) >= DEPTH;

    top_d = top_q;
    bot_d = bot_q;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    mem_addr_o = slot_of(lv, b);
    resp_o.status     = ST_EMPTY;
    resp_o.take       = 1'b0;
    resp_o.task_level = LEVEL_NONE;

    unique case (act)
      ACT_PUSH: begin
        if (!lv_ok || full) begin
          resp_o.status = ST_FULL;
        end else begin
          resp_o.status = ST_DONE;
          mem_we_o      = acc_i;
          mem_addr_o    = slot_of(lv, b);
          bot_d[lv]     = ring_next(b);
        end
      end
      ACT_POP: begin
        if (lv_ok && !empty) begin
          resp_o.status     = ST_DONE;
          resp_o.take       = 1'b1;
          resp_o.task_level = {1'b0, level_i};
          mem_re_o          = acc_i;
          mem_addr_o        = slot_of(lv, b_prev);
          if (b_prev == t) begin
            top_d[lv] = ring_next(t);
            bot_d[lv] = ring_next(t);
          end else begin
            bot_d[lv] = b_prev;
          end
        end
      end
      ACT_STEAL: begin
        if (lv_ok && !empty) begin
          resp_o.status     = ST_DONE;
          resp_o.take       = 1'b1;
          resp_o.task_level = {1'b0, level_i};
          mem_re_o          = acc_i;
          mem_addr_o        = slot_of(lv, t);
          top_d[lv]         = ring_next(t);
        end
      end
      default: begin
        resp_o.status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        top_q[i] <= '0;
        bot_q[i] <= '0;
      end
    end else if (acc_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

endmodule

/* rtl/priority_work_stealing_deques.sv */
`timescale 1ns / 1ps
// per-level task deques in one shared payload memory
// input channel: in_valid_i/in_ready_o carry one word of action_i, level_i and
// payload_i; action 0 pushes at the bottom, 1 pops the newest entry, 2 steals
// the oldest entry from the top of the deque chosen by level_i
// output channel: out_valid_o/out_ready_i carry one word per input word with
// status_o (0 done, 1 empty, 2 full), task_level_o (-1 when nothing is
// returned) and task_data_o (zero when nothing is returned)
// result path: the payload memory is read and the response kept in the read
// stage at the accepting edge; the output register loads from that stage
// throughput: one word per cycle while the receiver takes results; indices
// are updated at acceptance and the memory is written or read at the same
// edge, so back to back words on one deque see each other in order
// reset clears all top and bottom indices, so every deque starts empty; the
// payload memory is not cleared, no entry is read before it is written
// when the receiver stalls, the result is held and one further word may
// wait in the read stage; after that in_ready_o drops until out_ready_i
module priority_work_stealing_deques #(
  parameter int unsigned LEVELS       = 3,
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  level_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  task_level_o,
  output logic [31:0] task_data_o
);

  import pwsd_pkg::*;

  `include "priority_work_stealing_deques_assert.svh"

  localparam int unsigned ENTRIES = LEVELS * DEPTH;
  localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                    acc;
  logic                    out_load;
  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_addr;
  logic [PAYLOAD_BITS-1:0] mem_rdata;
  resp_t                   resp;

  logic        pend_q;
  resp_t       resp_q;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [2:0]  level_q;
  logic [31:0] data_q;

  assign out_load   = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || out_load;
  assign acc        = in_valid_i && in_ready_o;

  pwsd_ctrl #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .action_i   (action_i),
    .level_i    (level_i),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .resp_o     (resp)
  );

  pwsd_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .DW      (PAYLOAD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (PAYLOAD_BITS'(payload_i)),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      resp_q <= resp;
    end
    if (out_load) begin
      status_q <= resp_q.status;
      level_q  <= resp_q.task_level;
      data_q   <= resp_q.take ? 32'(mem_rdata) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign task_level_o = level_q;
  assign task_data_o  = data_q;

  // a waiting result is neither lost nor altered
  `PWSD_ASSERT(a_pend_hold, pend_q && !out_load |=> pend_q && $stable(resp_q), "pending word lost")
  // a memory read always leads to a pending result
  `PWSD_ASSERT(a_read_pend, mem_re |=> pend_q, "memory read without pending word")
  // a refused push carries no task
  `PWSD_ASSERT(a_full_none, out_valid_o && status_o == ST_FULL |-> task_level_o == LEVEL_NONE && task_data_o == '0, "full answer carries a task")
  // memory is never read and written in the same cycle
  `PWSD_ASSERT_ALWAYS(a_rw_excl, !(mem_we && mem_re), "memory read and write together")

endmodule
